### rtl/core/tlpc_pkg.sv
// Types and constants shared by the traffic light phase controller.
package tlpc_pkg;

    localparam int CFG_WIDTH     = 16;
    localparam int CFG_IDX_WIDTH = 2;

    typedef enum logic [2:0] {
        PH_A_GREEN  = 3'd0,
        PH_A_YELLOW = 3'd1,
        PH_B_GREEN  = 3'd2,
        PH_B_YELLOW = 3'd3,
        PH_NIGHT    = 3'd4
    } t_phase;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_GREEN_TIME  = 2'd0,
        CFG_YELLOW_TIME = 2'd1,
        CFG_NIGHT_TIME  = 2'd2
    } t_cfg_idx;

    localparam logic [CFG_WIDTH-1:0] GREEN_TIME_RST  = 16'd30;
    localparam logic [CFG_WIDTH-1:0] YELLOW_TIME_RST = 16'd5;
    localparam logic [CFG_WIDTH-1:0] NIGHT_TIME_RST  = 16'd300;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] green_time;
        logic [CFG_WIDTH-1:0] yellow_time;
        logic [CFG_WIDTH-1:0] night_idle_time;
    } t_timing;

    typedef struct packed {
        logic [2:0] phase;
        logic       changed;
    } t_result;

endpackage

### rtl/core/tlpc_intf.sv
// Channel interfaces: tick input, phase output and configuration write.
interface tlpc_in_if;
    logic valid;
    logic ready;
    logic traffic_a;
    logic traffic_b;

    modport source (output valid, output traffic_a, output traffic_b, input ready);
    modport sink   (input valid, input traffic_a, input traffic_b, output ready);
endinterface

interface tlpc_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] phase;
    logic       changed;

    modport source (output valid, output phase, output changed, input ready);
    modport sink   (input valid, input phase, input changed, output ready);
endinterface

interface tlpc_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [tlpc_pkg::CFG_IDX_WIDTH-1:0] index;
    logic [tlpc_pkg::CFG_WIDTH-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/tlpc_cfg_regs.sv
// Timing configuration registers of the traffic light phase controller.
module tlpc_cfg_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    tlpc_cfg_if.sink          i_cfg,
    output tlpc_pkg::t_timing o_timing
);

    tlpc_pkg::t_timing r_timing;
    tlpc_pkg::t_cfg_idx w_idx;

    assign i_cfg.ready = 1'b1;
    assign w_idx       = tlpc_pkg::t_cfg_idx'(i_cfg.index);
    assign o_timing    = r_timing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timing.green_time      <= tlpc_pkg::GREEN_TIME_RST;
            r_timing.yellow_time     <= tlpc_pkg::YELLOW_TIME_RST;
            r_timing.night_idle_time <= tlpc_pkg::NIGHT_TIME_RST;
        end else if (i_cfg.valid) begin
            unique case (w_idx)
                tlpc_pkg::CFG_GREEN_TIME:  r_timing.green_time      <= i_cfg.data;
                tlpc_pkg::CFG_YELLOW_TIME: r_timing.yellow_time     <= i_cfg.data;
                tlpc_pkg::CFG_NIGHT_TIME:  r_timing.night_idle_time <= i_cfg.data;
                default: ;
            endcase
        end
    end

endmodule

### rtl/core/tlpc_phase_core.sv
// Phase and elapsed-seconds state with the per-tick transition logic.
module tlpc_phase_core #(
    parameter int TIMER_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic              i_traffic_a,
    input  logic              i_traffic_b,
    input  tlpc_pkg::t_timing i_timing,
    output tlpc_pkg::t_result o_result
);

    localparam int CMP_W = (TIMER_BITS > tlpc_pkg::CFG_WIDTH) ? TIMER_BITS
                                                              : tlpc_pkg::CFG_WIDTH;
    typedef logic [CMP_W-1:0] t_cmp;

    tlpc_pkg::t_phase        r_phase;
    tlpc_pkg::t_phase        n_phase;
    logic [TIMER_BITS-1:0]   r_elapsed;
    logic [TIMER_BITS-1:0]   n_elapsed;
    t_cmp                    w_t;
    logic                    w_day;
    logic                    w_green_done;
    logic                    w_yellow_done;
    logic                    w_night_done;
    logic                    w_changed;

    assign w_t           = t_cmp'(r_elapsed);
    assign w_day         = (r_phase == tlpc_pkg::PH_A_GREEN)  ||
                           (r_phase == tlpc_pkg::PH_A_YELLOW) ||
                           (r_phase == tlpc_pkg::PH_B_GREEN)  ||
                           (r_phase == tlpc_pkg::PH_B_YELLOW);
    assign w_green_done  = w_t > t_cmp'(i_timing.green_time);
    assign w_yellow_done = w_t > t_cmp'(i_timing.yellow_time);
    assign w_night_done  = w_t > t_cmp'(i_timing.night_idle_time);

    always_comb begin
        n_phase = r_phase;
        if (w_day && !i_traffic_a && !i_traffic_b && w_night_done) begin
            n_phase = tlpc_pkg::PH_NIGHT;
        end else begin
            unique case (r_phase)
                tlpc_pkg::PH_A_GREEN: begin
                    if (i_traffic_b && w_green_done) n_phase = tlpc_pkg::PH_A_YELLOW;
                end
                tlpc_pkg::PH_A_YELLOW: begin
                    if (i_traffic_b && w_yellow_done) n_phase = tlpc_pkg::PH_B_GREEN;
                end
                tlpc_pkg::PH_B_GREEN: begin
                    if (i_traffic_a && w_green_done) n_phase = tlpc_pkg::PH_B_YELLOW;
                end
                tlpc_pkg::PH_B_YELLOW: begin
                    if (i_traffic_a && w_yellow_done) n_phase = tlpc_pkg::PH_A_GREEN;
                end
                tlpc_pkg::PH_NIGHT: begin
                    if (i_traffic_a) begin
                        n_phase = tlpc_pkg::PH_A_GREEN;
                    end else if (i_traffic_b) begin
                        n_phase = tlpc_pkg::PH_B_GREEN;
                    end
                end
                default: ;
            endcase
        end
    end

    assign w_changed = (n_phase != r_phase);

    always_comb begin
        if (w_changed) begin
            n_elapsed = '0;
        end else if (r_elapsed != '1) begin
            n_elapsed = r_elapsed + 1'b1;
        end else begin
            n_elapsed = r_elapsed;
        end
    end

    assign o_result.phase   = n_phase;
    assign o_result.changed = w_changed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= tlpc_pkg::PH_A_GREEN;
            r_elapsed <= '0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_elapsed <= n_elapsed;
        end
    end

    a_clear_on_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && w_changed |=> r_elapsed == '0)
        else $error("elapsed not cleared after phase change");

    a_hold_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_phase) && $stable(r_elapsed))
        else $error("state moved without a tick");

    a_count_when_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && !w_changed && r_elapsed != '1 |=> r_elapsed == $past(r_elapsed) + 1'b1)
        else $error("elapsed did not advance on a held phase");

endmodule

### rtl/core/traffic_light_phase_controller.sv
// Top level of the traffic light phase controller.
// A tick word is registered in the input register on accept, and its phase word
// is then registered in the output register once that register is free.
// Throughput: one tick word per cycle while the output is not stalled.
// The output register parts the two sides; a stalled output holds one word.
// Reset (synchronous, active low): phase A green, elapsed zero, registers
// green 30, yellow 5, night 300, no word held.
module traffic_light_phase_controller #(
    parameter int TIMER_BITS = 16
) (
    input logic       i_clk,
    input logic       i_rst_n,
    tlpc_in_if.sink   i_tick,
    tlpc_out_if.source o_phase,
    tlpc_cfg_if.sink  i_cfg
);

    tlpc_pkg::t_timing w_timing;
    tlpc_pkg::t_result w_result;

    logic       r_in_valid;
    logic       r_traffic_a;
    logic       r_traffic_b;
    logic       r_out_valid;
    logic [2:0] r_out_phase;
    logic       r_out_changed;
    logic       w_advance;

    assign w_advance    = r_in_valid && (!r_out_valid || o_phase.ready);
    assign i_tick.ready = !r_in_valid || w_advance;

    assign o_phase.valid   = r_out_valid;
    assign o_phase.phase   = r_out_phase;
    assign o_phase.changed = r_out_changed;

    tlpc_cfg_regs u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (i_cfg),
        .o_timing (w_timing)
    );

    tlpc_phase_core #(
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_advance),
        .i_traffic_a (r_traffic_a),
        .i_traffic_b (r_traffic_b),
        .i_timing    (w_timing),
        .o_result    (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_tick.ready) begin
                r_in_valid <= i_tick.valid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (o_phase.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tick.ready && i_tick.valid) begin
            r_traffic_a <= i_tick.traffic_a;
            r_traffic_b <= i_tick.traffic_b;
        end
        if (w_advance) begin
            r_out_phase   <= w_result.phase;
            r_out_changed <= w_result.changed;
        end
    end

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_out_valid && !o_phase.ready |-> !i_tick.ready)
        else $error("tick word taken while both stages are full");

endmodule

### tb/sv/tb_traffic_light_phase_controller.sv
// Self-checking testbench for the traffic light phase controller: directed table, soak, random.
`timescale 1ns / 100ps

module tb_traffic_light_phase_controller;

    localparam int TIMER_BITS      = 16;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int IDLE_PCT        = 37;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int SOAK_TICKS      = 40;
    localparam int SEGMENTS        = 10;
    localparam int SEG_TICKS       = 48;
    localparam int MAX_REPORTS     = 200;
    localparam int DIR_ROWS        = 25;

    localparam logic [tlpc_pkg::CFG_IDX_WIDTH-1:0] CFG_SPARE = 2'd3;

    typedef enum bit {ROW_TICK, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind                          kind;
        logic                               ta;
        logic                               tb;
        logic [tlpc_pkg::CFG_IDX_WIDTH-1:0] idx;
        logic [tlpc_pkg::CFG_WIDTH-1:0]     data;
        logic                               typed;
        tlpc_pkg::t_result                  want;
    } t_row;

    localparam t_row DIRECTED [DIR_ROWS] = '{
        '{ROW_TICK, 1'b0, 1'b0, tlpc_pkg::CFG_GREEN_TIME,  16'h0000,
          1'b1, '{tlpc_pkg::PH_A_GREEN, 1'b0}},
        '{ROW_TICK, 1'b1, 1'b1, tlpc_pkg::CFG_GREEN_TIME,  16'h0000,
          1'b1, '{tlpc_pkg::PH_A_GREEN, 1'b0}},
        '{ROW_CFG,  1'b0, 1'b0, tlpc_pkg::CFG_GREEN_TIME,  16'h0000,
          1'b0, '{tlpc_pkg::PH_A_GREEN, 1'b0}},
        '{ROW_CFG,  1'b0, 1'b0, tlpc_pkg::CFG_YELLOW_TIME, 16'h0000,
          1'b0, '{tlpc_pkg::PH_A_GREEN, 1'b0}},
        '{ROW_CFG,  1'b0, 1'b0, tlpc_pkg::CFG_NIGHT_TIME,  16'h0000,
          1'b0, '{tlpc_pkg::PH_A_GREEN, 1'b0}},
        '{ROW_TICK, 1'b0, 1'b1, tlpc_pkg::CFG_GREEN_TIME,  16'h0000,
          1'b0, '{tlpc_pkg::PH_A_GREEN, 1'b0}},
        '{ROW_TICK, 1'b0, 1'b1, tlpc_pkg::CFG_GREEN_TIME,  16'h0000,
          1'b0, '{tlpc_pkg::PH_A_GREEN, 1'b0}},
        '{ROW_TICK, 1'b0, 1'b1, tlpc_pkg::CFG_GREEN_TIME,  16'h0000,
          1'b0, '{tlpc_pkg::PH_A_GREEN, 1'b0}},
        '{ROW_TICK, 1'b0, 1'b0, tlpc_pkg::CFG_GREEN_TIME,  16'h0000,
          1'b0, '{tlpc_pkg::PH_A_GREEN, 1'b0}},
        '{ROW_TICK, 1'b0, 1'b0, tlpc_pkg::CFG_GREEN_TIME,  16'h0000,
          1'b0, '{tlpc_pkg::PH_A_GREEN, 1'b0}},
        '{ROW_TICK, 1'b0, 1'b0, tlpc_pkg::CFG_GREEN_TIME,  16'h0000,
          1'b1, '{tlpc_pkg::PH_NIGHT,   1'b0}},
        '{ROW_TICK, 1'b1, 1'b1, tlpc_pkg::CFG_GREEN_TIME,  16'h0000,
          1'b1, '{tlpc_pkg::PH_A_GREEN, 1'b1}},
        '{ROW_TICK, 1'b0, 1'b0, tlpc_pkg::CFG_GREEN_TIME,  16'h0000,
          1'b0, '{tlpc_pkg::PH_A_GREEN, 1'b0}},
        '{ROW_TICK, 1'b0, 1'b0, tlpc_pkg::CFG_GREEN_TIME,  16'h0000,
          1'b0, '{tlpc_pkg::PH_A_GREEN, 1'b0}},
        '{ROW_TICK, 1'b0, 1'b1, tlpc_pkg::CFG_GREEN_TIME,  16'h0000,
          1'b1, '{tlpc_pkg::PH_B_GREEN, 1'b1}},
        '{ROW_TICK, 1'b1, 1'b0, tlpc_pkg::CFG_GREEN_TIME,  16'h0000,
          1'b0, '{tlpc_pkg::PH_A_GREEN, 1'b0}},
        '{ROW_TICK, 1'b1, 1'b0, tlpc_pkg::CFG_GREEN_TIME,  16'h0000,
          1'b0, '{tlpc_pkg::PH_A_GREEN, 1'b0}},
        '{ROW_TICK, 1'b1, 1'b1, tlpc_pkg::CFG_GREEN_TIME,  16'h0000,
          1'b0, '{tlpc_pkg::PH_A_GREEN, 1'b0}},
        '{ROW_TICK, 1'b1, 1'b1, tlpc_pkg::CFG_GREEN_TIME,  16'h0000,
          1'b0, '{tlpc_pkg::PH_A_GREEN, 1'b0}},
        '{ROW_CFG,  1'b0, 1'b0, CFG_SPARE,                 16'hFFFF,
          1'b0, '{tlpc_pkg::PH_A_GREEN, 1'b0}},
        '{ROW_TICK, 1'b0, 1'b0, tlpc_pkg::CFG_GREEN_TIME,  16'h0000,
          1'b0, '{tlpc_pkg::PH_A_GREEN, 1'b0}},
        '{ROW_TICK, 1'b0, 1'b0, tlpc_pkg::CFG_GREEN_TIME,  16'h0000,
          1'b0, '{tlpc_pkg::PH_A_GREEN, 1'b0}},
        '{ROW_CFG,  1'b0, 1'b0, tlpc_pkg::CFG_GREEN_TIME,  16'hFFFF,
          1'b0, '{tlpc_pkg::PH_A_GREEN, 1'b0}},
        '{ROW_CFG,  1'b0, 1'b0, tlpc_pkg::CFG_YELLOW_TIME, 16'hFFFF,
          1'b0, '{tlpc_pkg::PH_A_GREEN, 1'b0}},
        '{ROW_CFG,  1'b0, 1'b0, tlpc_pkg::CFG_NIGHT_TIME,  16'hFFFF,
          1'b0, '{tlpc_pkg::PH_A_GREEN, 1'b0}}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    tlpc_in_if  tick_if ();
    tlpc_out_if phase_if ();
    tlpc_cfg_if cfg_if ();

    traffic_light_phase_controller #(
        .TIMER_BITS (TIMER_BITS)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tick  (tick_if),
        .o_phase (phase_if),
        .i_cfg   (cfg_if)
    );

    logic [tlpc_pkg::CFG_WIDTH-1:0] model_green;
    logic [tlpc_pkg::CFG_WIDTH-1:0] model_yellow;
    logic [tlpc_pkg::CFG_WIDTH-1:0] model_night;
    tlpc_pkg::t_phase               model_phase;
    logic [TIMER_BITS-1:0]          model_elapsed;

    tlpc_pkg::t_result expected_words [$];
    int      mismatches;
    int      cycle_count;
    bit      quiet;
    int      stall_req;
    int      stall_ack;
    int      hold_left;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic bit chance(int unsigned pct);
        return $urandom_range(99) < pct;
    endfunction

    function automatic tlpc_pkg::t_result tick_phase(logic ta, logic tb);
        tlpc_pkg::t_phase  nxt;
        tlpc_pkg::t_result word;
        nxt = model_phase;
        if (model_phase <= tlpc_pkg::PH_B_YELLOW && !ta && !tb && model_elapsed > model_night) begin
            nxt = tlpc_pkg::PH_NIGHT;
        end else begin
            case (model_phase)
                tlpc_pkg::PH_A_GREEN: begin
                    if (tb && model_elapsed > model_green) nxt = tlpc_pkg::PH_A_YELLOW;
                end
                tlpc_pkg::PH_A_YELLOW: begin
                    if (tb && model_elapsed > model_yellow) nxt = tlpc_pkg::PH_B_GREEN;
                end
                tlpc_pkg::PH_B_GREEN: begin
                    if (ta && model_elapsed > model_green) nxt = tlpc_pkg::PH_B_YELLOW;
                end
                tlpc_pkg::PH_B_YELLOW: begin
                    if (ta && model_elapsed > model_yellow) nxt = tlpc_pkg::PH_A_GREEN;
                end
                tlpc_pkg::PH_NIGHT: begin
                    if (ta) nxt = tlpc_pkg::PH_A_GREEN;
                    else if (tb) nxt = tlpc_pkg::PH_B_GREEN;
                end
                default: begin
                end
            endcase
        end
        word.changed = nxt != model_phase;
        word.phase   = nxt;
        if (word.changed) begin
            model_elapsed = '0;
        end else if (model_elapsed != '1) begin
            model_elapsed = model_elapsed + 1'b1;
        end
        model_phase = nxt;
        return word;
    endfunction

    function automatic logic [tlpc_pkg::CFG_WIDTH-1:0] pick_time(int unsigned small_max);
        int unsigned r;
        r = $urandom_range(9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        if (r == 2) return tlpc_pkg::CFG_WIDTH'($urandom);
        return tlpc_pkg::CFG_WIDTH'($urandom_range(small_max));
    endfunction

    task automatic send_tick(input logic ta, input logic tb, input logic typed,
                             input tlpc_pkg::t_result want);
        tlpc_pkg::t_result word;
        cfg_if.valid <= 1'b0;
        while (!quiet && chance(IDLE_PCT)) begin
            tick_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        tick_if.valid     <= 1'b1;
        tick_if.traffic_a <= ta;
        tick_if.traffic_b <= tb;
        @(posedge i_clk);
        while (!tick_if.ready) @(posedge i_clk);
        word = tick_phase(ta, tb);
        expected_words.push_back(typed ? want : word);
    endtask

    task automatic write_reg(input logic [tlpc_pkg::CFG_IDX_WIDTH-1:0] idx,
                             input logic [tlpc_pkg::CFG_WIDTH-1:0] data);
        tick_if.valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        case (idx)
            tlpc_pkg::CFG_GREEN_TIME:  model_green  = data;
            tlpc_pkg::CFG_YELLOW_TIME: model_yellow = data;
            tlpc_pkg::CFG_NIGHT_TIME:  model_night  = data;
            default: begin
            end
        endcase
    endtask

    task automatic report(input string what, input int want, input int got);
        if (mismatches < MAX_REPORTS) begin
            $display("%0t: %s expected %0d got %0d", $time, what, want, got);
        end
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        tlpc_pkg::t_result want;
        if (i_rst_n && phase_if.valid && phase_if.ready) begin
            if (expected_words.size() == 0) begin
                if (mismatches < MAX_REPORTS) begin
                    $display("%0t: unexpected phase word, expected none, got phase %0d changed %0d",
                             $time, phase_if.phase, phase_if.changed);
                end
                mismatches++;
            end else begin
                want = expected_words.pop_front();
                if (phase_if.phase !== want.phase) begin
                    report("phase", want.phase, phase_if.phase);
                end
                if (phase_if.changed !== want.changed) begin
                    report("changed", want.changed, phase_if.changed);
                end
            end
        end
        if (stall_ack != stall_req) begin
            hold_left = HOLD_OFF_CYCLES;
            stall_ack = stall_req;
        end
        if (hold_left != 0) begin
            hold_left--;
            phase_if.ready <= 1'b0;
        end else begin
            phase_if.ready <= quiet || !chance(IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int unsigned mode;
        int unsigned pa;
        int unsigned pb;
        i_rst_n           = 1'b0;
        tick_if.valid     = 1'b0;
        tick_if.traffic_a = 1'b0;
        tick_if.traffic_b = 1'b0;
        cfg_if.valid      = 1'b0;
        cfg_if.index      = tlpc_pkg::CFG_GREEN_TIME;
        cfg_if.data       = '0;
        phase_if.ready    = 1'b0;
        quiet             = 1'b0;
        stall_req         = 0;
        stall_ack         = 0;
        hold_left         = 0;
        mismatches        = 0;
        cycle_count       = 0;
        model_green       = tlpc_pkg::GREEN_TIME_RST;
        model_yellow      = tlpc_pkg::YELLOW_TIME_RST;
        model_night       = tlpc_pkg::NIGHT_TIME_RST;
        model_phase       = tlpc_pkg::PH_A_GREEN;
        model_elapsed     = '0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIR_ROWS; r++) begin
            if (DIRECTED[r].kind == ROW_CFG) begin
                write_reg(DIRECTED[r].idx, DIRECTED[r].data);
            end else begin
                send_tick(DIRECTED[r].ta, DIRECTED[r].tb, DIRECTED[r].typed,
                          DIRECTED[r].want);
            end
        end

        // hold the phase with every limit at the top
        for (int n = 0; n < SOAK_TICKS; n++) begin
            send_tick(1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0, '0);
        end
        write_reg(tlpc_pkg::CFG_GREEN_TIME, 16'hFFFE);
        write_reg(tlpc_pkg::CFG_YELLOW_TIME, 16'hFFFE);
        for (int n = 0; n < 8; n++) begin
            send_tick(1'b1, 1'b1, 1'b0, '0);
        end

        for (int s = 0; s < SEGMENTS; s++) begin
            quiet = (s == 3);
            write_reg(tlpc_pkg::CFG_GREEN_TIME, pick_time(6));
            write_reg(tlpc_pkg::CFG_YELLOW_TIME, pick_time(4));
            write_reg(tlpc_pkg::CFG_NIGHT_TIME, pick_time(25));
            if (chance(30)) write_reg(CFG_SPARE, tlpc_pkg::CFG_WIDTH'($urandom));
            if (s == 5 || s == 8) stall_req++;
            mode = $urandom_range(3);
            case (mode)
                0: begin pa = 50; pb = 50; end
                1: begin pa = 8;  pb = 8;  end
                2: begin pa = 85; pb = 15; end
                default: begin pa = 15; pb = 85; end
            endcase
            for (int n = 0; n < SEG_TICKS; n++) begin
                send_tick(chance(pa), chance(pb), 1'b0, '0);
            end
        end

        tick_if.valid <= 1'b0;
        cfg_if.valid  <= 1'b0;
        quiet = 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
